/* rtl/txrb_pkg.sv */
`default_nettype none

package txrb_pkg;

  // Item kinds on the input channel; the fourth code is unused and does nothing.
  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_FETCH = 2'd2;

  // One input transfer.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last_of_call;
    logic [7:0] fetch_offset;
  } item_t;

  // One result transfer.
  typedef struct packed {
    logic       accepted;
    logic [7:0] call_accepted_count;
    logic       start_valid;
    logic [7:0] start_offset;
    logic [7:0] start_length;
    logic [7:0] fetched_byte;
  } result_t;

  // Result of the control logic; the fetched byte comes later from the ring read port.
  typedef struct packed {
    logic       accepted;
    logic [7:0] call_accepted_count;
    logic       start_valid;
    logic [7:0] start_offset;
    logic [7:0] start_length;
    logic       is_fetch;
  } ctrl_res_t;

endpackage

`default_nettype wire

/* rtl/txrb_ring.sv */
`default_nettype none

module txrb_ring #(
  parameter int RING_DEPTH = 256,
  parameter int AW         = 8
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [RING_DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/txrb_ctrl.sv */
`default_nettype none

module txrb_ctrl #(
  parameter int RING_DEPTH = 256,
  parameter int AW         = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire txrb_pkg::item_t   item,
  output txrb_pkg::ctrl_res_t    res,
  output logic                   wr_en,
  output logic      [AW-1:0]     wr_addr,
  output logic      [7:0]        wr_data,
  output logic      [AW-1:0]     rd_addr
);

  import txrb_pkg::*;

  localparam logic [AW:0]   DEPTH_W = (AW+1)'(RING_DEPTH);
  localparam logic [AW:0]   FULL_W  = (AW+1)'(RING_DEPTH - 1);
  localparam logic [AW-1:0] LAST_IX = AW'(RING_DEPTH - 1);

  logic [AW-1:0] read_pointer, write_pointer, chunk_in_flight;
  logic [7:0]    call_count;
  logic          call_open, call_blocked;

  logic [AW-1:0] read_pointer_next, write_pointer_next, chunk_in_flight_next;
  logic [7:0]    call_count_next;
  logic          call_open_next, call_blocked_next;

  logic [AW:0]   used;
  logic          full, open_now, blocked_eff, store;
  logic [AW-1:0] wp_inc;
  logic [7:0]    cnt_base;
  logic [AW:0]   rp_sum;
  logic [AW-1:0] rp_adv;
  logic [AW-1:0] fetch_mod [256];

  // Chunk length from the read offset up to the write pointer or the ring end.
  function automatic logic [AW-1:0] chunk_len(input logic [AW-1:0] r, input logic [AW-1:0] w);
    logic [AW:0] len;
    if (r < w) begin
      len = {1'b0, w} - {1'b0, r};
    end else begin
      len = DEPTH_W - {1'b0, r};
    end
    return len[AW-1:0];
  endfunction

  // Fetch offsets reduced into the ring, as a constant table.
  for (genvar g = 0; g < 256; g++) begin : g_fetch_mod
    assign fetch_mod[g] = AW'(g % RING_DEPTH);
  end

  assign rd_addr = fetch_mod[item.fetch_offset];

  // Fill level and pointer arithmetic with wrap.
  always_comb begin
    used     = {1'b0, write_pointer} - {1'b0, read_pointer}
             + ((write_pointer < read_pointer) ? DEPTH_W : '0);
    full     = (used == FULL_W);
    wp_inc   = (write_pointer == LAST_IX) ? '0 : write_pointer + AW'(1);
    rp_sum   = {1'b0, read_pointer} + {1'b0, chunk_in_flight};
    rp_adv   = (rp_sum >= DEPTH_W) ? AW'(rp_sum - DEPTH_W) : rp_sum[AW-1:0];
    open_now    = !call_open;
    blocked_eff = open_now ? full : call_blocked;
    store       = !blocked_eff && !full;
    cnt_base    = open_now ? 8'd0 : call_count;
  end

  // Per-item state update and result.
  always_comb begin
    read_pointer_next    = read_pointer;
    write_pointer_next   = write_pointer;
    chunk_in_flight_next = chunk_in_flight;
    call_count_next      = call_count;
    call_open_next       = call_open;
    call_blocked_next    = call_blocked;
    res     = '0;
    wr_en   = 1'b0;
    wr_addr = write_pointer;
    wr_data = item.data_byte;
    unique case (item.kind)
      KIND_PUSH: begin
        wr_en                   = fire && store;
        res.accepted            = store;
        call_count_next         = cnt_base + 8'(store);
        res.call_accepted_count = call_count_next;
        if (store) begin
          write_pointer_next = wp_inc;
        end
        if (item.last_of_call) begin
          call_open_next    = 1'b0;
          call_blocked_next = 1'b0;
          if (!blocked_eff && chunk_in_flight == '0
              && read_pointer != write_pointer_next) begin
            chunk_in_flight_next = chunk_len(read_pointer, write_pointer_next);
            res.start_valid      = 1'b1;
            res.start_offset     = 8'(read_pointer);
            res.start_length     = 8'(chunk_in_flight_next);
          end
        end else begin
          call_open_next    = 1'b1;
          call_blocked_next = blocked_eff;
        end
      end
      KIND_DONE: begin
        if (chunk_in_flight != '0) begin
          read_pointer_next    = rp_adv;
          chunk_in_flight_next = '0;
          if (rp_adv != write_pointer) begin
            chunk_in_flight_next = chunk_len(rp_adv, write_pointer);
            res.start_valid      = 1'b1;
            res.start_offset     = 8'(rp_adv);
            res.start_length     = 8'(chunk_in_flight_next);
          end
        end
      end
      KIND_FETCH: begin
        res.is_fetch = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // State registers advance once per processed item.
  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer    <= '0;
      write_pointer   <= '0;
      chunk_in_flight <= '0;
      call_count      <= '0;
      call_open       <= 1'b0;
      call_blocked    <= 1'b0;
    end else if (fire) begin
      read_pointer    <= read_pointer_next;
      write_pointer   <= write_pointer_next;
      chunk_in_flight <= chunk_in_flight_next;
      call_count      <= call_count_next;
      call_open       <= call_open_next;
      call_blocked    <= call_blocked_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/tx_ring_buffer_dma_chunker.sv */
`default_nettype none

// Transmit byte ring that hands contiguous chunks to a DMA engine. Each input
// transfer is a push, a chunk-done event or a fetch, and gives exactly one result
// transfer. The block takes one item per clock cycle while the result side is not
// stalled. Each item is held in the input register, then the control logic and
// the ring's single write port and registered read port feed the result register.
// A stalled result holds the pipeline, and item_ready then falls. The ring store
// has no reset; fetching an entry that was never written returns an undefined
// byte. Pointers and chunk lengths are reported in their low 8 bits.
module tx_ring_buffer_dma_chunker #(
  parameter int RING_DEPTH = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire txrb_pkg::item_t   item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output txrb_pkg::result_t      result
);

  import txrb_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);

  item_t         s1_item;
  logic          s1_valid;
  ctrl_res_t     out_q;
  ctrl_res_t     ctrl_res;
  logic          out_load, fire;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;

  // Pipeline flow control.
  assign out_load   = !result_valid || result_ready;
  assign fire       = s1_valid && out_load;
  assign item_ready = !s1_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_ready) begin
        s1_valid <= item_valid;
      end
      if (out_load) begin
        result_valid <= s1_valid;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s1_item <= item;
    end
    if (fire) begin
      out_q <= ctrl_res;
    end
  end

  txrb_ctrl #(
    .RING_DEPTH(RING_DEPTH),
    .AW        (AW)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (s1_item),
    .res    (ctrl_res),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr)
  );

  txrb_ring #(
    .RING_DEPTH(RING_DEPTH),
    .AW        (AW)
  ) u_ring (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (fire),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Assemble the result; the fetched byte is zero for kinds other than fetch.
  always_comb begin
    result.accepted            = out_q.accepted;
    result.call_accepted_count = out_q.call_accepted_count;
    result.start_valid         = out_q.start_valid;
    result.start_offset        = out_q.start_offset;
    result.start_length        = out_q.start_length;
    result.fetched_byte        = out_q.is_fetch ? rd_data : 8'd0;
  end

endmodule

`default_nettype wire
